FILE: sv/shs_pkg.sv
// shs_pkg: shared types, widths, register indexes and reset values
// for the service health supervisor.
// No dependencies.
package shs_pkg;

  localparam int PROGRESS_W   = 32;
  localparam int PEER_W       = 17;
  localparam int NOW_W        = 32;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int FAIL_W       = 8;

  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 32;

  localparam logic [FAIL_W-1:0] FAIL_SAT = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STALL_LIMIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PEERS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIOLATION_TIME   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESTART_COOLDOWN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_LIMIT       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_WAIT        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_PERIOD    = 3'd7;

  // reset values
  localparam logic [15:0] DEF_STALL_LIMIT      = 16'd300;
  localparam logic [7:0]  DEF_MIN_PEERS        = 8'd2;
  localparam logic [15:0] DEF_GAP_LIMIT        = 16'd100;
  localparam logic [15:0] DEF_VIOLATION_TIME   = 16'd600;
  localparam logic [15:0] DEF_RESTART_COOLDOWN = 16'd900;
  localparam logic [7:0]  DEF_FAIL_LIMIT       = 8'd3;
  localparam logic [15:0] DEF_BOOT_WAIT        = 16'd120;
  localparam logic [15:0] DEF_STATUS_PERIOD    = 16'd600;

  typedef struct packed {
    logic [15:0] stall_limit;
    logic [7:0]  min_peers;
    logic [15:0] gap_limit;
    logic [15:0] violation_time;
    logic [15:0] restart_cooldown;
    logic [7:0]  fail_limit;
    logic [15:0] boot_wait;
    logic [15:0] status_period;
  } cfg_t;

  typedef struct packed {
    logic                         reachable;
    logic signed [PROGRESS_W-1:0] progress;
    logic signed [PEER_W-1:0]     peer_count;
    logic                         is_healthy;
    logic                         is_synced;
    logic                         sync_failed;
    logic signed [PROGRESS_W-1:0] remote_max;
    logic [NOW_W-1:0]             now_secs;
  } sample_t;

  typedef struct packed {
    logic unreachable_alert;
    logic boot_stall_alert;
    logic reach_recovered;
    logic stall_alert;
    logic regression_alert;
    logic peers_drop_alert;
    logic unhealthy_alert;
    logic health_recovered;
    logic failed_alert;
    logic lag_alert;
    logic restart_request;
    logic status_pulse;
  } result_t;

endpackage

FILE: sv/shs_if.sv
// shs_if: valid/ready channel interfaces for health samples and results.
// Depends on shs_pkg.
interface shs_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  reachable;
  logic signed [shs_pkg::PROGRESS_W-1:0] progress;
  logic signed [shs_pkg::PEER_W-1:0]     peer_count;
  logic                                  is_healthy;
  logic                                  is_synced;
  logic                                  sync_failed;
  logic signed [shs_pkg::PROGRESS_W-1:0] remote_max;
  logic [shs_pkg::NOW_W-1:0]             now_secs;

  modport source (output valid, reachable, progress, peer_count, is_healthy,
                  is_synced, sync_failed, remote_max, now_secs, input ready);
  modport sink (input valid, reachable, progress, peer_count, is_healthy,
                is_synced, sync_failed, remote_max, now_secs, output ready);
endinterface

interface shs_out_if;
  logic valid;
  logic ready;
  logic unreachable_alert;
  logic boot_stall_alert;
  logic reach_recovered;
  logic stall_alert;
  logic regression_alert;
  logic peers_drop_alert;
  logic unhealthy_alert;
  logic health_recovered;
  logic failed_alert;
  logic lag_alert;
  logic restart_request;
  logic status_pulse;

  modport source (output valid, unreachable_alert, boot_stall_alert, reach_recovered,
                  stall_alert, regression_alert, peers_drop_alert, unhealthy_alert,
                  health_recovered, failed_alert, lag_alert, restart_request,
                  status_pulse, input ready);
  modport sink (input valid, unreachable_alert, boot_stall_alert, reach_recovered,
                stall_alert, regression_alert, peers_drop_alert, unhealthy_alert,
                health_recovered, failed_alert, lag_alert, restart_request,
                status_pulse, output ready);
endinterface

FILE: sv/shs_cfg.sv
// shs_cfg: configuration register bank, write-only.
// Depends on shs_pkg.
module shs_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [shs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [shs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output shs_pkg::cfg_t                    cfg
);
  import shs_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stall_limit      <= DEF_STALL_LIMIT;
      cfg_r.min_peers        <= DEF_MIN_PEERS;
      cfg_r.gap_limit        <= DEF_GAP_LIMIT;
      cfg_r.violation_time   <= DEF_VIOLATION_TIME;
      cfg_r.restart_cooldown <= DEF_RESTART_COOLDOWN;
      cfg_r.fail_limit       <= DEF_FAIL_LIMIT;
      cfg_r.boot_wait        <= DEF_BOOT_WAIT;
      cfg_r.status_period    <= DEF_STATUS_PERIOD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STALL_LIMIT:      cfg_r.stall_limit      <= cfg_data;
        REG_MIN_PEERS:        cfg_r.min_peers        <= cfg_data[7:0];
        REG_GAP_LIMIT:        cfg_r.gap_limit        <= cfg_data;
        REG_VIOLATION_TIME:   cfg_r.violation_time   <= cfg_data;
        REG_RESTART_COOLDOWN: cfg_r.restart_cooldown <= cfg_data;
        REG_FAIL_LIMIT:       cfg_r.fail_limit       <= cfg_data[7:0];
        REG_BOOT_WAIT:        cfg_r.boot_wait        <= cfg_data;
        REG_STATUS_PERIOD:    cfg_r.status_period    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/shs_core.sv
// shs_core: supervisor state and the per-sample checks.
// Result is combinational from the held sample and state; state moves on fire.
// Depends on shs_pkg.
module shs_core #(
  parameter int TIME_BITS  = shs_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = shs_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  shs_pkg::cfg_t     cfg,
  input  shs_pkg::sample_t  smp,
  input  logic              fire,
  output shs_pkg::result_t  res
);
  import shs_pkg::*;

  localparam int TW = TIME_BITS;
  localparam int CW = (COUNT_BITS < 32) ? COUNT_BITS : 32;

  function automatic logic el_gt(logic [TW-1:0] now, logic [TW-1:0] t, logic [15:0] lim);
    logic [TW-1:0] d;
    d = now - t;
    return (now >= t) && (d > TW'(lim));
  endfunction

  function automatic logic el_ge(logic [TW-1:0] now, logic [TW-1:0] t, logic [15:0] lim);
    logic [TW-1:0] d;
    d = now - t;
    return (now >= t) && (d >= TW'(lim));
  endfunction

  // state
  logic                     started_r, prev_healthy_r, ever_reached_r, boot_done_r;
  logic                     lag_armed_r, restarted_r, status_done_r;
  logic [TW-1:0]            start_time_r, progress_time_r, status_time_r;
  logic [TW-1:0]            lag_onset_r, restart_time_r;
  logic signed [CW-1:0]     prev_progress_r;
  logic signed [PEER_W-1:0] prev_peers_r;
  logic [FAIL_W-1:0]        fail_count_r;

  logic                     prev_healthy_nxt, ever_reached_nxt, boot_done_nxt;
  logic                     lag_armed_nxt, restarted_nxt, status_done_nxt;
  logic [TW-1:0]            start_time_nxt, progress_time_nxt, status_time_nxt;
  logic [TW-1:0]            lag_onset_nxt, restart_time_nxt;
  logic signed [CW-1:0]     prev_progress_nxt;
  logic signed [PEER_W-1:0] prev_peers_nxt;
  logic [FAIL_W-1:0]        fail_count_nxt;

  // sample decode
  logic [63:0]              now_ext;
  logic [TW-1:0]            now;
  logic signed [CW-1:0]     prog, remote;
  logic signed [CW+1:0]     lead;
  logic signed [PEER_W-1:0] minp;
  logic [TW-1:0]            st_time, pr_time, onset;
  logic [FAIL_W-1:0]        fail_inc;
  logic                     prog_pos, prev_pos, remote_pos, lag_cond;
  result_t                  r;

  assign now_ext  = 64'(smp.now_secs);
  assign now      = now_ext[TW-1:0];
  assign prog     = smp.progress[CW-1:0];
  assign remote   = smp.remote_max[CW-1:0];
  assign lead     = (CW+2)'(remote) - (CW+2)'(prog);
  assign minp     = $signed({{(PEER_W-8){1'b0}}, cfg.min_peers});
  assign prog_pos   = !prog[CW-1] && (prog != '0);
  assign prev_pos   = !prev_progress_r[CW-1] && (prev_progress_r != '0);
  assign remote_pos = !remote[CW-1] && (remote != '0);
  assign lag_cond = remote_pos && prog_pos &&
                    (lead > $signed({{(CW+2-16){1'b0}}, cfg.gap_limit}));

  // first sample seeds the start and progress times
  assign st_time  = started_r ? start_time_r : now;
  assign pr_time  = started_r ? progress_time_r : now;
  assign onset    = lag_armed_r ? lag_onset_r : now;
  assign fail_inc = (fail_count_r == FAIL_SAT) ? fail_count_r : fail_count_r + 1'b1;

  always_comb begin
    r                 = '0;
    start_time_nxt    = st_time;
    progress_time_nxt = pr_time;
    fail_count_nxt    = fail_count_r;
    ever_reached_nxt  = ever_reached_r;
    boot_done_nxt     = boot_done_r;
    prev_progress_nxt = prev_progress_r;
    prev_peers_nxt    = prev_peers_r;
    prev_healthy_nxt  = prev_healthy_r;
    lag_armed_nxt     = lag_armed_r;
    lag_onset_nxt     = lag_onset_r;
    restarted_nxt     = restarted_r;
    restart_time_nxt  = restart_time_r;
    status_done_nxt   = status_done_r;
    status_time_nxt   = status_time_r;

    if (!smp.reachable) begin
      fail_count_nxt      = fail_inc;
      r.unreachable_alert = fail_inc >= cfg.fail_limit;
      if (!ever_reached_r && !boot_done_r && el_gt(now, st_time, cfg.boot_wait)) begin
        r.boot_stall_alert = 1'b1;
        boot_done_nxt      = 1'b1;
      end
    end else begin
      r.reach_recovered = fail_count_r != '0;
      fail_count_nxt    = '0;
      ever_reached_nxt  = 1'b1;

      if (prog > prev_progress_r) begin
        progress_time_nxt = now;
      end else begin
        r.stall_alert = prev_pos && !smp.is_synced &&
                        el_gt(now, pr_time, cfg.stall_limit);
      end

      r.regression_alert = prog_pos && prev_pos && (prog < prev_progress_r);
      r.peers_drop_alert = (smp.peer_count < minp) && (prev_peers_r >= minp);
      r.unhealthy_alert  = !smp.is_healthy && prev_healthy_r;
      r.health_recovered = smp.is_healthy && !prev_healthy_r && started_r;
      r.failed_alert     = smp.sync_failed;

      if (lag_cond) begin
        lag_armed_nxt = 1'b1;
        lag_onset_nxt = onset;
        if (el_gt(now, onset, cfg.violation_time)) begin
          r.lag_alert = 1'b1;
          if (!restarted_r || el_ge(now, restart_time_r, cfg.restart_cooldown)) begin
            r.restart_request = 1'b1;
            restart_time_nxt  = now;
            restarted_nxt     = 1'b1;
            lag_armed_nxt     = 1'b0;
            lag_onset_nxt     = '0;
          end
        end
      end else begin
        lag_armed_nxt = 1'b0;
        lag_onset_nxt = '0;
      end

      if (!status_done_r || el_ge(now, status_time_r, cfg.status_period)) begin
        r.status_pulse  = 1'b1;
        status_time_nxt = now;
        status_done_nxt = 1'b1;
      end

      prev_progress_nxt = prog;
      prev_peers_nxt    = smp.peer_count;
      prev_healthy_nxt  = smp.is_healthy;
    end
  end

  assign res = r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r       <= 1'b0;
      start_time_r    <= '0;
      progress_time_r <= '0;
      fail_count_r    <= '0;
      ever_reached_r  <= 1'b0;
      boot_done_r     <= 1'b0;
      prev_progress_r <= '0;
      prev_peers_r    <= '0;
      prev_healthy_r  <= 1'b0;
      lag_armed_r     <= 1'b0;
      lag_onset_r     <= '0;
      restarted_r     <= 1'b0;
      restart_time_r  <= '0;
      status_done_r   <= 1'b0;
      status_time_r   <= '0;
    end else if (fire) begin
      started_r       <= 1'b1;
      start_time_r    <= start_time_nxt;
      progress_time_r <= progress_time_nxt;
      fail_count_r    <= fail_count_nxt;
      ever_reached_r  <= ever_reached_nxt;
      boot_done_r     <= boot_done_nxt;
      prev_progress_r <= prev_progress_nxt;
      prev_peers_r    <= prev_peers_nxt;
      prev_healthy_r  <= prev_healthy_nxt;
      lag_armed_r     <= lag_armed_nxt;
      lag_onset_r     <= lag_onset_nxt;
      restarted_r     <= restarted_nxt;
      restart_time_r  <= restart_time_nxt;
      status_done_r   <= status_done_nxt;
      status_time_r   <= status_time_nxt;
    end
  end

endmodule

FILE: sv/service_health_supervisor_top.sv
// service_health_supervisor_top: health sample supervisor, top level.
// Depends on shs_pkg, shs_if, shs_cfg and shs_core.
//
// Usage:
//   in_chan  - one health sample per item (valid/ready).
//   out_chan - one item of twelve alert/status flags per sample, in order.
//   cfg_*    - write-only register port; cfg_we writes cfg_data to the
//              register at cfg_index on the clock edge. Write only when idle.
// Flow: a sample accepted into the input register is checked against the
// supervisor state and lands in the result register once that register frees
// up, and its result is offered on out_chan from there.
// Throughput: one item per cycle while out_chan does not stall; the state update is a single pass of
// compares and subtracts between the input register and the result register.
// Reset (rst_n low, synchronous): both stages empty, all supervisor state
// cleared, registers back to their defaults.
// Stall: while out_chan.ready is low with a result offered, the result holds,
// the input register keeps its sample and no state moves; in_chan.ready is
// high while the input register is empty or drains, so one further item is taken.
module service_health_supervisor_top #(
  parameter int TIME_BITS  = shs_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = shs_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  shs_in_if.sink                         in_chan,
  shs_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [shs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import shs_pkg::*;

  cfg_t    cfg;
  sample_t smp_r;
  result_t res, res_r;
  logic    s1_v_r, out_v_r;
  logic    adv, in_acc;

  shs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  shs_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .smp   (smp_r),
    .fire  (adv),
    .res   (res)
  );

  // held item moves to the result register when that register frees up
  assign adv            = s1_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready  = !s1_v_r || adv;
  assign in_acc         = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc)
        s1_v_r <= 1'b1;
      else if (adv)
        s1_v_r <= 1'b0;
      if (adv)
        out_v_r <= 1'b1;
      else if (out_chan.ready)
        out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r.reachable   <= in_chan.reachable;
      smp_r.progress    <= in_chan.progress;
      smp_r.peer_count  <= in_chan.peer_count;
      smp_r.is_healthy  <= in_chan.is_healthy;
      smp_r.is_synced   <= in_chan.is_synced;
      smp_r.sync_failed <= in_chan.sync_failed;
      smp_r.remote_max  <= in_chan.remote_max;
      smp_r.now_secs    <= in_chan.now_secs;
    end
    if (adv)
      res_r <= res;
  end

  assign out_chan.valid             = out_v_r;
  assign out_chan.unreachable_alert = res_r.unreachable_alert;
  assign out_chan.boot_stall_alert  = res_r.boot_stall_alert;
  assign out_chan.reach_recovered   = res_r.reach_recovered;
  assign out_chan.stall_alert       = res_r.stall_alert;
  assign out_chan.regression_alert  = res_r.regression_alert;
  assign out_chan.peers_drop_alert  = res_r.peers_drop_alert;
  assign out_chan.unhealthy_alert   = res_r.unhealthy_alert;
  assign out_chan.health_recovered  = res_r.health_recovered;
  assign out_chan.failed_alert      = res_r.failed_alert;
  assign out_chan.lag_alert         = res_r.lag_alert;
  assign out_chan.restart_request   = res_r.restart_request;
  assign out_chan.status_pulse      = res_r.status_pulse;

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !s1_v_r && !out_v_r)
    else $error("pipeline not empty after reset");

  // a held sample is never dropped while the result side is blocked
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv |=> s1_v_r)
    else $error("held sample lost under stall");

  // a restart request only comes with a lag alert
  a_restart_lag: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.restart_request |-> res_r.lag_alert)
    else $error("restart without lag alert");

  // an unreachable sample yields only the reachability alerts
  a_unreach_only: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !smp_r.reachable |=> !res_r.status_pulse && !res_r.reach_recovered &&
                                !res_r.lag_alert)
    else $error("unreachable sample produced other flags");

endmodule
